// ===== rtl/core/char_lcd_nibble_write_sequencer_top_defines.svh =====
// ----------------------------------------------------------------------------
// char lcd nibble write sequencer assertion macros
// clocked assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_DEFINES_SVH

// condition must hold on every clock outside reset
`define CLNWS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// same-cycle implication outside reset
`define CLNWS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication outside reset
`define CLNWS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/clnws_pkg.sv =====
// ----------------------------------------------------------------------------
// clnws_pkg
// types, codes and helpers of the character lcd nibble write sequencer
// ----------------------------------------------------------------------------
package clnws_pkg;

   // widest column count accepted by position requests
   localparam int COLUMNS = 16;

   // spans in milliseconds
   localparam logic [3:0] SPAN_BYTE_MS  = 4'd1;
   localparam logic [3:0] SPAN_HOME_MS  = 4'd2;
   localparam logic [3:0] SPAN_SYNC_MS  = 4'd5;
   localparam logic [3:0] SPAN_POWER_MS = 4'd15;

   // init sequence steps
   localparam logic [2:0] STEP_NONE  = 3'd0;
   localparam logic [2:0] STEP_SYNC0 = 3'd1;
   localparam logic [2:0] STEP_SYNC1 = 3'd2;
   localparam logic [2:0] STEP_LAST  = 3'd6;

   localparam logic [7:0] CMD_HOME      = 8'h02;
   localparam logic [7:0] CMD_SYNC0     = 8'h33;
   localparam logic [7:0] CMD_SYNC1     = 8'h32;
   localparam logic [7:0] CMD_FUNC_SET  = 8'h2C;
   localparam logic [3:0] CMD_DISP_CTRL = 4'h0;
   localparam logic [7:0] CMD_CLEAR     = 8'h01;
   localparam logic [7:0] CMD_HOME_ADDR = 8'h80;

   typedef enum logic [1:0] {
      MODE_TICK = 2'd0,
      MODE_BYTE = 2'd1,
      MODE_POS  = 2'd2,
      MODE_INIT = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_NONE    = 2'd0,
      ST_ACCEPT  = 2'd1,
      ST_BUSY    = 2'd2,
      ST_BAD_POS = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_TICKS_PER_MS = 2'd0,
      CSR_SHOW_CURSOR  = 2'd1,
      CSR_CURSOR_BLINK = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_HI_HIGH   = 3'd1,
      PH_HI_LOW    = 3'd2,
      PH_LO_HIGH   = 3'd3,
      PH_TRAIL     = 3'd4,
      PH_INIT_WAIT = 3'd5
   } phase_type;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  data_byte;
      logic        is_char;
      logic [4:0]  column;
      logic [1:0]  row;
   } req_item_type;

   typedef struct packed {
      logic        pin_rs;
      logic        pin_rw;
      logic        pin_e;
      logic [3:0]  pin_db;
      logic        ready_res;
      status_type  status;
   } rsp_item_type;

   typedef struct packed {
      logic [19:0] ticks_per_ms;
      logic        show_cursor;
      logic        cursor_blink;
   } cfg_type;

   // ticks in a span of ms milliseconds, rate of zero counts as one
   function automatic logic [23:0] ms_span(logic [19:0] tpm, logic [3:0] ms);
      logic [19:0] t;
      t = (tpm == 20'd0) ? 20'd1 : tpm;
      return 24'({4'b0, t} * {20'b0, ms});
   endfunction

   // command byte sent at each init step
   function automatic logic [7:0] init_byte(logic [2:0] step, logic cur_on,
                                            logic cur_blink);
      logic [7:0] b;
      case (step)
         3'd1:    b = CMD_SYNC0;
         3'd2:    b = CMD_SYNC1;
         3'd3:    b = CMD_FUNC_SET;
         3'd4:    b = {CMD_DISP_CTRL, 1'b1, 1'b1, cur_on, cur_blink};
         3'd5:    b = CMD_CLEAR;
         default: b = CMD_HOME_ADDR;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/core/char_lcd_nibble_write_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_top
// 4-bit character lcd write sequencer with tick-based timing
// ----------------------------------------------------------------------------
// Every req beat (tick or request) yields exactly one rsp beat carrying the
// lcd pin levels after that beat, whether the block is idle, and a status.
// The block takes one beat per clock while the result register is free or
// draining: a beat lands in the input register, then updates the sequencer
// state and its result lands in the result register, which drives rsp_valid.
// The per-beat work is one 24-bit tick counter decrement or reload (span =
// ticks_per_ms times 1, 2, 5 or 15) plus the phase machine. Bytes go out high
// nibble first, each nibble with an e pulse of 1 ms high and 1 ms low, the
// low nibble's low time being the trailing wait (1 ms, 2 ms after the home
// command, 5 ms after the two sync bytes). Requests while busy return status
// busy; csr writes are taken at any time and should only be issued while no
// beat is in flight.
module char_lcd_nibble_write_sequencer_top import clnws_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   // request channel
   input  logic          req_valid,
   output logic          req_ready,
   input  req_item_type  req_data,
   // result channel
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_item_type  rsp_data,
   // configuration write channel
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [19:0]   csr_data
);

   // configuration registers
   cfg_type      cfg_ff, cfg_in;

   // input register
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff, s1_item_in;

   // result register
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;

   logic         advance;
   rsp_item_type step_result;

   // csr writes never stall; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TICKS_PER_MS: cfg_in.ticks_per_ms = csr_data;
            CSR_SHOW_CURSOR:  cfg_in.show_cursor  = csr_data[0];
            CSR_CURSOR_BLINK: cfg_in.cursor_blink = csr_data[0];
            default:          ;
         endcase
      end
   end

   // the held beat moves on when the result register is free or draining
   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
         s1_item_in  = req_data;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // state update and result for the held beat
   clnws_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (s1_item_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_item_in  = step_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_ms <= 20'd50000;
         cfg_ff.show_cursor  <= 1'b0;
         cfg_ff.cursor_blink <= 1'b0;
         s1_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      out_item_ff <= out_item_in;
   end

endmodule

// ===== rtl/core/clnws_seq.sv =====
// ----------------------------------------------------------------------------
// clnws_seq
// nibble sequencer state: timing counter, phase machine and pin levels
// ----------------------------------------------------------------------------
module clnws_seq import clnws_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   phase_type   phase_ff, phase_in;
   logic [23:0] wait_ff, wait_in;
   logic [7:0]  byte_ff, byte_in;
   logic        rs_ff, rs_in;
   logic [2:0]  step_ff, step_in;
   logic [1:0]  trail_ff, trail_in;
   logic        pin_rs_ff, pin_rs_in;
   logic        pin_e_ff, pin_e_in;
   logic [3:0]  pin_db_ff, pin_db_in;

   logic [23:0] span_byte, span_trail, span_sync, span_power;
   logic        pos_ok;
   logic [7:0]  pos_byte;
   status_type  status;

   assign span_byte  = ms_span(cfg.ticks_per_ms, SPAN_BYTE_MS);
   assign span_trail = ms_span(cfg.ticks_per_ms, {2'b0, trail_ff});
   assign span_sync  = ms_span(cfg.ticks_per_ms, SPAN_SYNC_MS);
   assign span_power = ms_span(cfg.ticks_per_ms, SPAN_POWER_MS);

   // row 1 adds 0x40 to the column
   assign pos_ok   = (item.row <= 2'd1) && ({1'b0, item.column} < 6'(COLUMNS));
   assign pos_byte = {1'b1, item.row[0], 1'b0, item.column};

   // next state
   always_comb begin
      logic       start_go;
      logic [7:0] start_b;
      logic       start_rs;
      phase_in  = phase_ff;
      wait_in   = wait_ff;
      byte_in   = byte_ff;
      rs_in     = rs_ff;
      step_in   = step_ff;
      trail_in  = trail_ff;
      pin_rs_in = pin_rs_ff;
      pin_e_in  = pin_e_ff;
      pin_db_in = pin_db_ff;
      start_go  = 1'b0;
      start_b   = byte_ff;
      start_rs  = 1'b0;
      if (fire) begin
         if (item.mode == MODE_TICK) begin
            if (phase_ff != PH_IDLE) begin
               if (wait_ff > 24'd1) begin
                  wait_in = wait_ff - 24'd1;
               end else begin
                  case (phase_ff)
                     PH_HI_HIGH: begin
                        pin_e_in = 1'b0;
                        phase_in = PH_HI_LOW;
                        wait_in  = span_byte;
                     end
                     PH_HI_LOW: begin
                        pin_e_in  = 1'b1;
                        pin_db_in = byte_ff[3:0];
                        phase_in  = PH_LO_HIGH;
                        wait_in   = span_byte;
                     end
                     PH_LO_HIGH: begin
                        pin_e_in = 1'b0;
                        phase_in = PH_TRAIL;
                        if (step_ff inside {STEP_SYNC0, STEP_SYNC1}) begin
                           wait_in = span_sync;
                        end else begin
                           wait_in = span_trail;
                        end
                     end
                     PH_TRAIL: begin
                        if (step_ff inside {[STEP_SYNC0 : STEP_LAST - 3'd1]}) begin
                           step_in  = step_ff + 3'd1;
                           start_go = 1'b1;
                           start_b  = init_byte(step_ff + 3'd1, cfg.show_cursor,
                                                cfg.cursor_blink);
                        end else begin
                           step_in  = STEP_NONE;
                           phase_in = PH_IDLE;
                           wait_in  = 24'd0;
                        end
                     end
                     PH_INIT_WAIT: begin
                        start_go = 1'b1;
                        start_b  = init_byte(step_ff, cfg.show_cursor, cfg.cursor_blink);
                     end
                     default: begin
                        phase_in = PH_IDLE;
                        step_in  = STEP_NONE;
                        wait_in  = 24'd0;
                     end
                  endcase
               end
            end
         end else if (phase_ff == PH_IDLE) begin
            case (item.mode)
               MODE_BYTE: begin
                  start_go = 1'b1;
                  start_b  = item.data_byte;
                  start_rs = item.is_char;
               end
               MODE_POS: begin
                  start_go = pos_ok;
                  start_b  = pos_byte;
               end
               MODE_INIT: begin
                  step_in  = STEP_SYNC0;
                  phase_in = PH_INIT_WAIT;
                  wait_in  = span_power;
               end
               default: ;
            endcase
         end
      end
      if (start_go) begin
         byte_in   = start_b;
         rs_in     = start_rs;
         trail_in  = (!start_rs && start_b == CMD_HOME) ? 2'd2 : 2'd1;
         pin_rs_in = start_rs;
         pin_e_in  = 1'b1;
         pin_db_in = start_b[7:4];
         phase_in  = PH_HI_HIGH;
         wait_in   = span_byte;
      end
   end

   // outputs
   always_comb begin
      if (item.mode == MODE_TICK) begin
         status = ST_NONE;
      end else if (phase_ff != PH_IDLE) begin
         status = ST_BUSY;
      end else if (item.mode == MODE_POS && !pos_ok) begin
         status = ST_BAD_POS;
      end else begin
         status = ST_ACCEPT;
      end
      result.pin_rs    = pin_rs_in;
      result.pin_rw    = 1'b0;
      result.pin_e     = pin_e_in;
      result.pin_db    = pin_db_in;
      result.ready_res = (phase_in == PH_IDLE);
      result.status    = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         wait_ff   <= 24'd0;
         byte_ff   <= 8'd0;
         rs_ff     <= 1'b0;
         step_ff   <= STEP_NONE;
         trail_ff  <= 2'd1;
         pin_rs_ff <= 1'b0;
         pin_e_ff  <= 1'b0;
         pin_db_ff <= 4'd0;
      end else begin
         phase_ff  <= phase_in;
         wait_ff   <= wait_in;
         byte_ff   <= byte_in;
         rs_ff     <= rs_in;
         step_ff   <= step_in;
         trail_ff  <= trail_in;
         pin_rs_ff <= pin_rs_in;
         pin_e_ff  <= pin_e_in;
         pin_db_ff <= pin_db_in;
      end
   end

endmodule

// ===== rtl/core/clnws_checker.sv =====
// ----------------------------------------------------------------------------
// clnws_checker
// port-level checks of the character lcd nibble write sequencer
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_write_sequencer_top_defines.svh"

module clnws_checker import clnws_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input rsp_item_type  rsp_data,
   input logic          csr_ready
);

   // stalled result beat holds
   `CLNWS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp beat changed while stalled")

   // busy means the sequencer was and stays busy
   `CLNWS_ASSERT_IMPLY(a_busy_not_ready, rsp_valid && rsp_data.status == ST_BUSY, !rsp_data.ready_res, "busy status with ready_res set")

   // an ignored position leaves the block idle
   `CLNWS_ASSERT_IMPLY(a_bad_pos_idle, rsp_valid && rsp_data.status == ST_BAD_POS, rsp_data.ready_res, "bad position left block busy")

   // an idle sequencer never leaves e high
   `CLNWS_ASSERT_IMPLY(a_idle_e_low, rsp_valid && rsp_data.ready_res, !rsp_data.pin_e && !rsp_data.pin_rw, "e high or rw set while idle")

   // csr writes never stall
   `CLNWS_ASSERT_ALWAYS(a_csr_ready, csr_ready, "csr_ready dropped")

endmodule

bind char_lcd_nibble_write_sequencer_top clnws_checker u_clnws_checker (.*);

// ===== test/tb_char_lcd_nibble_write_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_write_sequencer_top
// self-checking bench for the 4-bit character lcd write sequencer: a local
// predictor follows every req beat and the pin levels, ready flag and status
// of each rsp beat are compared against it, under random stalls on both sides
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_write_sequencer_top;
   timeunit 1ns;
   timeprecision 1ps;

   import clnws_pkg::*;

   // init steps past the two sync bytes
   localparam logic [2:0] STEP_FUNC    = 3'd3;
   localparam logic [2:0] STEP_DISPLAY = 3'd4;
   localparam logic [2:0] STEP_CLEAR   = 3'd5;

   // command encodings used by the predictor
   localparam logic [7:0] DISPLAY_ON_CMD = 8'h0C;
   localparam logic [7:0] SET_ADDR_CMD   = 8'h80;
   localparam logic [6:0] ROW1_BASE      = 7'h40;

   localparam logic [19:0] TICKS_MAX = 20'hFFFFF;

   // random part: phases of useful beats, one rate setting per phase
   localparam int RANDOM_PHASES    = 6;
   localparam int BEATS_PER_PHASE  = 190;

   // ---------------------------------------------------------------------
   // dut signals, all inputs known from time zero
   // ---------------------------------------------------------------------
   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_item_type  req_data  = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_item_type  rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [1:0]    csr_index = CSR_TICKS_PER_MS;
   logic [19:0]   csr_data  = '0;

   char_lcd_nibble_write_sequencer_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // bench state
   // ---------------------------------------------------------------------
   rsp_item_type pending_rsp[$];   // pin levels and status still to come
   int           fail_count = 0;
   int           rsp_hold   = 0;   // cycles the rsp side still stalls
   bit           no_idle    = 1'b0; // both sides run back to back while set
   bit           req_hot    = 1'b0; // req_valid still high after its beat
   bit           csr_hot    = 1'b0; // csr_valid still high after its beat

   // ---------------------------------------------------------------------
   // predicted sequencer state and its settings
   // ---------------------------------------------------------------------
   phase_type   seq_phase;
   logic [23:0] seq_count;      // ticks left in the current timed phase
   logic [7:0]  seq_byte;       // byte being clocked out
   logic        seq_rs;
   logic [2:0]  seq_init_step;  // STEP_NONE outside the power-up sequence
   logic [3:0]  seq_trail_ms;   // trailing wait of the byte in flight
   logic        lcd_rs;
   logic        lcd_e;
   logic [3:0]  lcd_db;
   logic [19:0] cfg_ticks_per_ms;
   logic        cfg_show_cursor;
   logic        cfg_cursor_blink;

   task automatic model_reset();
      seq_phase        = PH_IDLE;
      seq_count        = '0;
      seq_byte         = '0;
      seq_rs           = 1'b0;
      seq_init_step    = STEP_NONE;
      seq_trail_ms     = SPAN_BYTE_MS;
      lcd_rs           = 1'b0;
      lcd_e            = 1'b0;
      lcd_db           = '0;
      cfg_ticks_per_ms = 20'd50000;
      cfg_show_cursor  = 1'b0;
      cfg_cursor_blink = 1'b0;
   endtask

   // ticks in a span, a zero rate behaves as one tick per ms
   function automatic logic [23:0] ms_ticks(logic [3:0] ms);
      logic [23:0] rate;
      rate = (cfg_ticks_per_ms == '0) ? 24'd1 : {4'b0, cfg_ticks_per_ms};
      return 24'(rate * ms);
   endfunction

   function automatic void drive_pins(logic rs, logic e, logic [3:0] nib);
      lcd_rs = rs;
      lcd_e  = e;
      lcd_db = nib;
   endfunction

   // high nibble goes out first with e raised
   function automatic void begin_byte(logic [7:0] b, logic rs);
      seq_byte     = b;
      seq_rs       = rs;
      seq_trail_ms = (!rs && b == CMD_HOME) ? SPAN_HOME_MS : SPAN_BYTE_MS;
      drive_pins(rs, 1'b1, b[7:4]);
      seq_phase    = PH_HI_HIGH;
      seq_count    = ms_ticks(SPAN_BYTE_MS);
   endfunction

   // cursor bits are sampled when the display control byte starts
   function automatic logic [7:0] power_up_cmd(logic [2:0] step);
      logic [7:0] cmd;
      case (step)
         STEP_SYNC0:   cmd = CMD_SYNC0;
         STEP_SYNC1:   cmd = CMD_SYNC1;
         STEP_FUNC:    cmd = CMD_FUNC_SET;
         STEP_DISPLAY: cmd = DISPLAY_ON_CMD | {6'b0, cfg_show_cursor, cfg_cursor_blink};
         STEP_CLEAR:   cmd = CMD_CLEAR;
         default:      cmd = SET_ADDR_CMD;
      endcase
      return cmd;
   endfunction

   // action taken on the tick that ends a timed phase
   function automatic void phase_done();
      case (seq_phase)
         PH_HI_HIGH: begin
            drive_pins(seq_rs, 1'b0, seq_byte[7:4]);
            seq_phase = PH_HI_LOW;
            seq_count = ms_ticks(SPAN_BYTE_MS);
         end
         PH_HI_LOW: begin
            drive_pins(seq_rs, 1'b1, seq_byte[3:0]);
            seq_phase = PH_LO_HIGH;
            seq_count = ms_ticks(SPAN_BYTE_MS);
         end
         PH_LO_HIGH: begin
            drive_pins(seq_rs, 1'b0, seq_byte[3:0]);
            seq_phase = PH_TRAIL;
            // the two sync bytes get the long settle instead of the trail
            seq_count = ms_ticks((seq_init_step == STEP_SYNC0 ||
                                  seq_init_step == STEP_SYNC1) ? SPAN_SYNC_MS
                                                               : seq_trail_ms);
         end
         PH_TRAIL: begin
            if (seq_init_step >= STEP_SYNC0 && seq_init_step < STEP_LAST) begin
               seq_init_step = seq_init_step + 3'd1;
               begin_byte(power_up_cmd(seq_init_step), 1'b0);
            end else begin
               seq_init_step = STEP_NONE;
               seq_phase     = PH_IDLE;
               seq_count     = '0;
            end
         end
         PH_INIT_WAIT: begin
            begin_byte(power_up_cmd(seq_init_step), 1'b0);
         end
         default: begin
            seq_phase     = PH_IDLE;
            seq_init_step = STEP_NONE;
            seq_count     = '0;
         end
      endcase
   endfunction

   // advance the predictor by one req beat and return the rsp it causes
   function automatic rsp_item_type lcd_step(req_item_type it);
      rsp_item_type res;
      status_type   st;
      logic [6:0]   addr;
      st = ST_NONE;
      if (it.mode == MODE_TICK) begin
         if (seq_phase != PH_IDLE) begin
            if (seq_count > 24'd1) seq_count = seq_count - 24'd1;
            else phase_done();
         end
      end else if (seq_phase != PH_IDLE) begin
         // busy wins over a bad position
         st = ST_BUSY;
      end else begin
         case (it.mode)
            MODE_BYTE: begin
               begin_byte(it.data_byte, it.is_char);
               st = ST_ACCEPT;
            end
            MODE_POS: begin
               if (it.row <= 2'd1 && it.column < COLUMNS) begin
                  addr = {2'b00, it.column} + (it.row[0] ? ROW1_BASE : 7'd0);
                  begin_byte(SET_ADDR_CMD | {1'b0, addr}, 1'b0);
                  st = ST_ACCEPT;
               end else begin
                  st = ST_BAD_POS;
               end
            end
            default: begin
               seq_init_step = STEP_SYNC0;
               seq_phase     = PH_INIT_WAIT;
               seq_count     = ms_ticks(SPAN_POWER_MS);
               st            = ST_ACCEPT;
            end
         endcase
      end
      res.pin_rs    = lcd_rs;
      res.pin_rw    = 1'b0;
      res.pin_e     = lcd_e;
      res.pin_db    = lcd_db;
      res.ready_res = (seq_phase == PH_IDLE);
      res.status    = st;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // beat builders, unused fields always carry random bits
   // ---------------------------------------------------------------------
   function automatic req_item_type noise_item(mode_type m);
      req_item_type it;
      {it.data_byte, it.is_char, it.column, it.row} = 16'($urandom);
      it.mode = m;
      return it;
   endfunction

   function automatic req_item_type byte_item(logic [7:0] b, logic ch);
      req_item_type it;
      it           = noise_item(MODE_BYTE);
      it.data_byte = b;
      it.is_char   = ch;
      return it;
   endfunction

   function automatic req_item_type pos_item(logic [1:0] row, logic [4:0] col);
      req_item_type it;
      it        = noise_item(MODE_POS);
      it.row    = row;
      it.column = col;
      return it;
   endfunction

   function automatic int pick_gap();
      return no_idle ? 0 : $urandom_range(0, 5);
   endfunction

   // ---------------------------------------------------------------------
   // channel drivers
   // ---------------------------------------------------------------------

   // drop any valid left high after its beat; time must advance afterwards
   task automatic release_channels();
      if (req_hot) req_valid <= 1'b0;
      if (csr_hot) csr_valid <= 1'b0;
      req_hot = 1'b0;
      csr_hot = 1'b0;
   endtask

   // one req beat; valid stays up if the next beat follows without a gap
   task automatic send_item(req_item_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         release_channels();
         repeat (gap) @(posedge clock);
      end else if (csr_hot) begin
         csr_valid <= 1'b0;
         csr_hot = 1'b0;
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      req_hot = 1'b1;
      pending_rsp.push_back(lcd_step(it));
   endtask

   // hold off until every expected rsp beat is in
   task automatic wait_drained();
      if (pending_rsp.size() != 0) release_channels();
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // register write, only with nothing in flight
   task automatic write_csr(csr_index_type idx, logic [19:0] val);
      if (req_hot) begin
         req_valid <= 1'b0;
         req_hot = 1'b0;
      end
      while (pending_rsp.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_hot = 1'b1;
      case (idx)
         CSR_TICKS_PER_MS: cfg_ticks_per_ms = val;
         CSR_SHOW_CURSOR:  cfg_show_cursor  = val[0];
         CSR_CURSOR_BLINK: cfg_cursor_blink = val[0];
         default: ;
      endcase
   endtask

   // feed time until the predicted sequencer is back to idle
   task automatic tick_until_idle();
      while (seq_phase != PH_IDLE) send_item(noise_item(MODE_TICK));
   endtask

   // ---------------------------------------------------------------------
   // rsp side: random stalls and the field-by-field check
   // ---------------------------------------------------------------------
   task automatic compare_field(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_hold = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected rsp beat, expected none, actual %p",
                        $time, rsp_data);
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               compare_field("pin_rs", 4'(want.pin_rs), 4'(rsp_data.pin_rs));
               compare_field("pin_rw", 4'(want.pin_rw), 4'(rsp_data.pin_rw));
               compare_field("pin_e", 4'(want.pin_e), 4'(rsp_data.pin_e));
               compare_field("pin_db", want.pin_db, rsp_data.pin_db);
               compare_field("ready_res", 4'(want.ready_res), 4'(rsp_data.ready_res));
               compare_field("status", 4'(want.status), 4'(rsp_data.status));
            end
            rsp_hold = pick_gap();
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_ready <= (rsp_hold == 0);
      end
   end

   // ---------------------------------------------------------------------
   // directed tests
   // ---------------------------------------------------------------------

   // reset rate is huge, so only beats that leave the block idle here
   task automatic test_idle_after_reset();
      send_item(noise_item(MODE_TICK));
      send_item(noise_item(MODE_TICK));
      send_item(pos_item(2'd2, 5'd3));     // row past the second line
      send_item(pos_item(2'd0, 5'd16));    // first column past the edge
      send_item(pos_item(2'd3, 5'd31));    // both out of range
   endtask

   // largest and zero tick rate, cursor bits set
   task automatic test_csr_extremes();
      write_csr(CSR_TICKS_PER_MS, TICKS_MAX);
      write_csr(CSR_SHOW_CURSOR, 20'd1);
      write_csr(CSR_CURSOR_BLINK, 20'hFFFFF);
      send_item(noise_item(MODE_TICK));
      send_item(pos_item(2'd1, 5'd16));
      // zero rate must behave like one tick per ms
      write_csr(CSR_TICKS_PER_MS, 20'd0);
      send_item(byte_item(8'hFF, 1'b1));
      send_item(byte_item(8'h00, 1'b0));   // busy
      tick_until_idle();
   endtask

   // plain bytes, home command trail, requests while busy
   task automatic test_byte_writes();
      write_csr(CSR_TICKS_PER_MS, 20'd5);
      send_item(byte_item(8'h00, 1'b0));
      send_item(noise_item(MODE_INIT));    // busy
      send_item(pos_item(2'd3, 5'd31));    // busy even though position is bad
      send_item(pos_item(2'd0, 5'd0));     // busy with a good position
      tick_until_idle();
      write_csr(CSR_TICKS_PER_MS, 20'd2);
      send_item(byte_item(CMD_HOME, 1'b0)); // home command, long trail
      tick_until_idle();
      send_item(byte_item(CMD_HOME, 1'b1)); // same byte as data, normal trail
      tick_until_idle();
      send_item(byte_item(8'hA5, 1'b1));
      tick_until_idle();
   endtask

   // corners of both rows plus rejected positions
   task automatic test_cursor_positions();
      write_csr(CSR_TICKS_PER_MS, 20'd1);
      send_item(pos_item(2'd0, 5'd0));
      tick_until_idle();
      send_item(pos_item(2'd0, 5'd15));
      tick_until_idle();
      send_item(pos_item(2'd1, 5'd0));
      tick_until_idle();
      send_item(pos_item(2'd1, 5'd15));
      tick_until_idle();
      send_item(pos_item(2'd0, 5'd16));
      send_item(pos_item(2'd1, 5'd31));
      send_item(pos_item(2'd2, 5'd0));
      send_item(pos_item(2'd3, 5'd15));
   endtask

   // power-up sequence under three of the four cursor settings
   task automatic test_init_sequence();
      write_csr(CSR_SHOW_CURSOR, 20'd1);
      write_csr(CSR_CURSOR_BLINK, 20'd0);
      send_item(noise_item(MODE_INIT));
      send_item(byte_item(8'h41, 1'b1));   // busy during the power-on wait
      tick_until_idle();
      write_csr(CSR_SHOW_CURSOR, 20'hFFFFE);
      write_csr(CSR_CURSOR_BLINK, 20'd1);
      write_csr(CSR_TICKS_PER_MS, 20'd3);
      send_item(noise_item(MODE_INIT));
      tick_until_idle();
      write_csr(CSR_SHOW_CURSOR, 20'd1);
      write_csr(CSR_TICKS_PER_MS, 20'd2);
      send_item(noise_item(MODE_INIT));
      tick_until_idle();
   endtask

   // ---------------------------------------------------------------------
   // random traffic: mostly requests while idle, mostly ticks while busy
   // ---------------------------------------------------------------------
   task automatic test_random_traffic();
      req_item_type it;
      int           roll;
      int           useful;
      int           rate;
      bit           counts;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         rate = (p == 0) ? 1 : (p == 1) ? 0 : $urandom_range(1, 4);
         write_csr(CSR_TICKS_PER_MS, 20'(rate));
         write_csr(CSR_SHOW_CURSOR, 20'($urandom));
         write_csr(CSR_CURSOR_BLINK, 20'($urandom));
         useful = 0;
         while (useful < BEATS_PER_PHASE) begin
            // stretches without any idling on either side
            if ($urandom_range(0, 39) == 0) no_idle = ($urandom_range(0, 2) == 0);
            // now and then let everything drain before going on
            if ($urandom_range(0, 79) == 0) wait_drained();
            it   = noise_item(MODE_TICK);
            roll = $urandom_range(0, 99);
            if (seq_phase == PH_IDLE) begin
               if (roll < 70) begin
                  roll = $urandom_range(0, 99);
                  it   = noise_item(MODE_BYTE);
                  if (roll < 10) begin
                     it.mode = MODE_INIT;
                  end else if (roll < 45) begin
                     it.mode = MODE_POS;
                     // mostly on-screen positions, the rest anything
                     if ($urandom_range(0, 4) != 0) begin
                        it.row    = 2'($urandom_range(0, 1));
                        it.column = 5'($urandom_range(0, COLUMNS - 1));
                     end
                  end else if (roll < 55) begin
                     it.data_byte = CMD_HOME;
                     it.is_char   = 1'b0;
                  end
               end
            end else if (roll < 8) begin
               it.mode = mode_type'($urandom_range(1, 3));   // rejected as busy
            end
            counts = (seq_phase != PH_IDLE) ? (it.mode == MODE_TICK)
                                            : (it.mode != MODE_TICK);
            send_item(it);
            if (counts) useful++;
         end
         no_idle = 1'b0;
         tick_until_idle();
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      model_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_idle_after_reset();
      test_csr_extremes();
      test_byte_writes();
      test_cursor_positions();
      test_init_sequence();
      test_random_traffic();
      // let the last beats through, then allow for the pipeline latency
      release_channels();
      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
